>>> src/dq_pkg.sv
// shared types and codes for the double-ended queue
`timescale 1ns / 1ps

package dq_pkg;

  // command codes carried on the input channel
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_SHOW       = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DATA  = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    resp_load;
    status_e resp_status;
    logic    walk_clear;
    logic    walk_read;
    logic    walk_emit;
  } dq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
    logic out_free;
  } dq_sts_t;

endpackage

>>> src/dq_ctrl.sv
// controller state machine for the double-ended queue
`timescale 1ns / 1ps

module dq_ctrl
  import dq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_cmd,
  input  dq_sts_t    sts,
  output dq_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.resp_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              cmd.resp_load = 1'b1;
              if (sts.full) begin
                cmd.resp_status = ST_FULL;
              end else begin
                cmd.push_front = (in_cmd == CMD_PUSH_FRONT);
                cmd.push_back  = (in_cmd == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              cmd.resp_load = 1'b1;
              if (sts.empty) begin
                cmd.resp_status = ST_EMPTY;
              end else begin
                cmd.pop_front = (in_cmd == CMD_POP_FRONT);
                cmd.pop_back  = (in_cmd == CMD_POP_BACK);
              end
            end
            CMD_SHOW: begin
              if (sts.empty) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = ST_EMPTY;
              end else begin
                cmd.walk_clear = 1'b1;
                state_nxt      = S_READ;
              end
            end
            default: begin
              // unused codes are dropped without a result
            end
          endcase
        end
      end
      S_READ: begin
        cmd.walk_read = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.walk_emit = 1'b1;
          state_nxt     = sts.walk_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/dq_datapath.sv
// ring store, pointers and output register of the double-ended queue
`timescale 1ns / 1ps

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_value,
  input  dq_cmd_t            cmd,
  output dq_sts_t            sts,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic signed [31:0] out_data,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [31:0]       mem [DEPTH];
  logic [IDX_W-1:0]  front_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [31:0]       rd_data_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  status_e           out_status_r;
  logic              out_last_r;

  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  front_inc;
  logic [IDX_W-1:0]  back_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;

  // ring position base + off, off never above DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  // address generation
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign back_addr = ring_add(front_r, count_r);
  assign rd_addr   = ring_add(front_r, idx_r);
  assign wr_en     = cmd.push_front || cmd.push_back;
  assign wr_addr   = cmd.push_front ? front_dec : back_addr;

  // status back to the controller
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == DEPTH_C);
  assign sts.walk_last = ((idx_r + 1'b1) == count_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  // ring store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.walk_read) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // front pointer, fill count and walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.push_front) begin
        front_r <= front_dec;
      end else if (cmd.pop_front) begin
        front_r <= front_inc;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.pop_front || cmd.pop_back) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.walk_clear) begin
        idx_r <= '0;
      end else if (cmd.walk_emit) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load || cmd.walk_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_data_r   <= '0;
      out_status_r <= cmd.resp_status;
      out_last_r   <= 1'b1;
    end else if (cmd.walk_emit) begin
      out_data_r   <= rd_data_r;
      out_status_r <= ST_DATA;
      out_last_r   <= sts.walk_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> src/double_ended_queue.sv
// top level of the bounded double-ended queue
//
// Input channel in_*: one transaction carries one command (in_tuser) and a
// push value (in_tdata). Output channel out_*: each result carries a stored
// value (out_tdata, zero unless it is a show data item), a status
// (out_tuser) and out_tlast on the final result of the command.
// Push and pop results are registered on the edge that accepts the command
// and show on the next cycle. Show walks the ring store through its single
// registered read port, entry by entry (read, then load the output register;
// an output stall holds the walk); input is held off (in_tready low) for the
// whole walk.
// A new command is accepted in the cycle its predecessor's result is taken.
// Unused command codes are accepted and produce no result.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; stored values are not cleared. When the receiver stalls, the
// result holds in the output register and no further command is accepted.
`timescale 1ns / 1ps

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  dq_cmd_t cmd;
  dq_sts_t sts;
  logic    in_accept;

  assign in_accept = in_tvalid && in_tready;

  // controller
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  // a successful push leaves the queue non-empty
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == CMD_PUSH_FRONT || in_tuser == CMD_PUSH_BACK) && !sts.full
    |=> !sts.empty)
    else $error("queue empty after successful push");

  // a push into a full queue reports full as a single result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == CMD_PUSH_FRONT || in_tuser == CMD_PUSH_BACK) && sts.full
    |=> out_tvalid && out_tuser == ST_FULL && out_tlast)
    else $error("push into full queue did not report full");

  // a show of a non-empty queue holds off input while it walks
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tuser == CMD_SHOW && !sts.empty |=> !in_tready)
    else $error("input accepted during show walk");

  // status-only results carry zero data and the last mark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DATA |-> out_tdata == '0 && out_tlast)
    else $error("status result with data or without last mark");

endmodule
